// File: rtl/mdp_pkg.sv
`timescale 1ns / 1ps

package mdp_pkg;

  localparam int MOTOR_COUNT = 4;
  localparam int MOTOR_IDX_W = $clog2(MOTOR_COUNT);
  localparam int VAL_W = 16;
  localparam int DUTY_W = 16;
  localparam int MM_W = 15;
  localparam int CFG_W = 16;
  localparam int PROD_W = 31;
  localparam int QUOT_W = 16;

  typedef enum logic [1:0] {
    OP_SET_ALL = 2'd0,
    OP_SET_ONE = 2'd1,
    OP_READ    = 2'd2
  } opcode_t;

  typedef enum logic [1:0] {
    CFG_CMD_LIMIT  = 2'd0,
    CFG_MIN_THRUST = 2'd1,
    CFG_MAX_THRUST = 2'd2
  } cfg_index_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MAX,
    ST_SCALE_MUL,
    ST_SCALE_DIV,
    ST_SCALE_WAIT,
    ST_MAP_MUL,
    ST_MAP_DIV,
    ST_MAP_WAIT,
    ST_NEXT,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic accept;
    logic find_max;
    logic mul_scale;
    logic pass_scaled;
    logic div_start;
    logic div_map;
    logic take_scaled;
    logic mul_map;
    logic duty_min;
    logic take_duty;
    logic next_motor;
    logic publish;
  } cmd_t;

  typedef struct packed {
    logic rescale;
    logic map_trivial;
    logic last;
    logic div_done;
    logic out_free;
  } status_t;

endpackage

// File: rtl/motor_desaturate_to_pwm.sv
`timescale 1ns / 1ps

// Four signed motor commands are held in the block. Each input item on the
// item channel (item_valid, item_stall) sets all four commands, sets one, or
// reads one. The block then rescales the commands so that none exceeds
// motor_max and maps each to a duty cycle between min_thrust and max_thrust.
// One result item per input item leaves on the result channel (result_valid,
// result_stall) with the four duties and, for a read, the stored command.
// The user must write the three registers through cfg_write, cfg_index and
// cfg_data only while no item is in progress; the block itself does not enforce this.
// A single shared divider settles one quotient bit per cycle and serves up to
// eight divisions per item: a rescale and a mapping for each motor. A motor
// skips the rescale division when no command exceeds motor_max, and the
// mapping division when its command is negative or motor_max is zero. The
// next item is accepted once the result has been moved to the output
// register, even while that result still waits to be taken.
// Reset clears the commands to zero and restores the register defaults.
// While result_stall is high the result is held and the finished next item
// waits until the output register is free.
module motor_desaturate_to_pwm (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              item_valid,
  output logic                              item_stall,
  input  logic [1:0]                        opcode,
  input  logic [1:0]                        index,
  input  logic signed [mdp_pkg::VAL_W-1:0]  value_0,
  input  logic signed [mdp_pkg::VAL_W-1:0]  value_1,
  input  logic signed [mdp_pkg::VAL_W-1:0]  value_2,
  input  logic signed [mdp_pkg::VAL_W-1:0]  value_3,
  output logic                              result_valid,
  input  logic                              result_stall,
  output logic [mdp_pkg::DUTY_W-1:0]        duty_0,
  output logic [mdp_pkg::DUTY_W-1:0]        duty_1,
  output logic [mdp_pkg::DUTY_W-1:0]        duty_2,
  output logic [mdp_pkg::DUTY_W-1:0]        duty_3,
  output logic signed [mdp_pkg::VAL_W-1:0]  read_value,
  input  logic                              cfg_write,
  input  logic [1:0]                        cfg_index,
  input  logic [mdp_pkg::CFG_W-1:0]         cfg_data
);
  import mdp_pkg::*;

  cmd_t    cmd;
  status_t status;

  mdp_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .status     (status),
    .cmd        (cmd)
  );

  mdp_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .opcode       (opcode),
    .index        (index),
    .value_0      (value_0),
    .value_1      (value_1),
    .value_2      (value_2),
    .value_3      (value_3),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .duty_0       (duty_0),
    .duty_1       (duty_1),
    .duty_2       (duty_2),
    .duty_3       (duty_3),
    .read_value   (read_value)
  );

endmodule

// File: rtl/mdp_div.sv
`timescale 1ns / 1ps

module mdp_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [mdp_pkg::PROD_W-1:0]    dividend,
  input  logic [mdp_pkg::MM_W-1:0]      divisor,
  output logic [mdp_pkg::QUOT_W-1:0]    quotient,
  output logic                          busy
);
  import mdp_pkg::*;

  localparam int CNT_W = $clog2(QUOT_W);

  logic [MM_W-1:0]   rem;
  logic [MM_W-1:0]   div_reg;
  logic [QUOT_W-1:0] low;
  logic [CNT_W-1:0]  count;
  logic [MM_W:0]     trial;
  logic              ge;

  // The quotient is known to fit in QUOT_W bits, so the upper dividend bits
  // start below the divisor and one quotient bit is settled per cycle.
  assign trial = {rem, low[QUOT_W-1]};
  assign ge = trial >= {1'b0, div_reg};
  assign quotient = low;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy <= 1'b1;
      count <= '0;
    end else if (busy) begin
      count <= count + 1'b1;
      if (count == CNT_W'(QUOT_W - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= dividend[PROD_W-1:QUOT_W];
      low <= dividend[QUOT_W-1:0];
      div_reg <= divisor;
    end else if (busy) begin
      rem <= ge ? MM_W'(trial - {1'b0, div_reg}) : trial[MM_W-1:0];
      low <= {low[QUOT_W-2:0], ge};
    end
  end

endmodule

// File: rtl/mdp_dp.sv
`timescale 1ns / 1ps

module mdp_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  mdp_pkg::cmd_t                     cmd,
  output mdp_pkg::status_t                  status,
  input  logic [1:0]                        opcode,
  input  logic [1:0]                        index,
  input  logic signed [mdp_pkg::VAL_W-1:0]  value_0,
  input  logic signed [mdp_pkg::VAL_W-1:0]  value_1,
  input  logic signed [mdp_pkg::VAL_W-1:0]  value_2,
  input  logic signed [mdp_pkg::VAL_W-1:0]  value_3,
  input  logic                              cfg_write,
  input  logic [1:0]                        cfg_index,
  input  logic [mdp_pkg::CFG_W-1:0]         cfg_data,
  output logic                              result_valid,
  input  logic                              result_stall,
  output logic [mdp_pkg::DUTY_W-1:0]        duty_0,
  output logic [mdp_pkg::DUTY_W-1:0]        duty_1,
  output logic [mdp_pkg::DUTY_W-1:0]        duty_2,
  output logic [mdp_pkg::DUTY_W-1:0]        duty_3,
  output logic signed [mdp_pkg::VAL_W-1:0]  read_value
);
  import mdp_pkg::*;

  logic [MM_W-1:0]          motor_max;
  logic [DUTY_W-1:0]        min_thrust;
  logic [DUTY_W-1:0]        max_thrust;
  logic signed [VAL_W-1:0]  store [MOTOR_COUNT];
  logic signed [VAL_W-1:0]  largest;
  logic                     rescale;
  logic [MOTOR_IDX_W-1:0]   motor;
  logic signed [VAL_W-1:0]  scaled;
  logic                     neg;
  logic                     diff_neg;
  logic [PROD_W-1:0]        product;
  logic [DUTY_W-1:0]        duty [MOTOR_COUNT];
  logic signed [VAL_W-1:0]  read_work;

  logic signed [VAL_W-1:0]  max_01;
  logic signed [VAL_W-1:0]  max_23;
  logic signed [VAL_W-1:0]  max_all;
  logic signed [VAL_W-1:0]  cur;
  logic [VAL_W-1:0]         cur_mag;
  logic signed [DUTY_W:0]   diff;
  logic [DUTY_W-1:0]        diff_mag;
  logic [15:0]              mul_x;
  logic [15:0]              mul_y;
  logic [31:0]              mul_full;
  logic [MM_W-1:0]          divisor;
  logic [QUOT_W-1:0]        quotient;
  logic                     div_busy;
  logic signed [DUTY_W+1:0] duty_sum;
  logic [DUTY_W-1:0]        duty_sat;
  logic                     out_free;

  assign max_01 = (store[1] > store[0]) ? store[1] : store[0];
  assign max_23 = (store[3] > store[2]) ? store[3] : store[2];
  assign max_all = (max_23 > max_01) ? max_23 : max_01;

  assign cur = store[motor];
  assign cur_mag = cur[VAL_W-1] ? VAL_W'(-cur) : cur;
  assign diff = $signed({1'b0, max_thrust}) - $signed({1'b0, min_thrust});
  assign diff_mag = diff[DUTY_W] ? DUTY_W'(-diff) : diff[DUTY_W-1:0];

  assign mul_x = cmd.mul_map ? {1'b0, scaled[MM_W-1:0]} : cur_mag;
  assign mul_y = cmd.mul_map ? diff_mag : {1'b0, motor_max};
  assign mul_full = mul_x * mul_y;

  assign divisor = cmd.div_map ? motor_max : largest[MM_W-1:0];

  mdp_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (product),
    .divisor  (divisor),
    .quotient (quotient),
    .busy     (div_busy)
  );

  assign duty_sum = diff_neg ?
      $signed({2'b00, min_thrust}) - $signed({2'b00, quotient}) :
      $signed({2'b00, min_thrust}) + $signed({2'b00, quotient});

  always_comb begin
    if (duty_sum[DUTY_W+1]) begin
      duty_sat = '0;
    end else if (duty_sum[DUTY_W]) begin
      duty_sat = '1;
    end else begin
      duty_sat = duty_sum[DUTY_W-1:0];
    end
  end

  assign out_free = !result_valid || !result_stall;

  assign status.rescale = rescale;
  assign status.map_trivial = scaled[VAL_W-1] || (motor_max == '0);
  assign status.last = motor == MOTOR_IDX_W'(MOTOR_COUNT - 1);
  assign status.div_done = !div_busy;
  assign status.out_free = out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      motor_max <= MM_W'(1000);
      min_thrust <= DUTY_W'(1000);
      max_thrust <= DUTY_W'(2000);
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_CMD_LIMIT:  motor_max <= cfg_data[MM_W-1:0];
        CFG_MIN_THRUST: min_thrust <= cfg_data;
        CFG_MAX_THRUST: max_thrust <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MOTOR_COUNT; i++) begin
        store[i] <= '0;
      end
    end else if (cmd.accept) begin
      case (opcode)
        OP_SET_ALL: begin
          store[0] <= value_0;
          store[1] <= value_1;
          store[2] <= value_2;
          store[3] <= value_3;
        end
        OP_SET_ONE: store[index] <= value_0;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      read_work <= (opcode == OP_READ) ? store[index] : '0;
    end
    if (cmd.find_max) begin
      largest <= max_all;
      rescale <= max_all > $signed({1'b0, motor_max});
    end
    if (cmd.mul_scale) begin
      product <= mul_full[PROD_W-1:0];
      neg <= cur[VAL_W-1];
    end
    if (cmd.mul_map) begin
      product <= mul_full[PROD_W-1:0];
      diff_neg <= diff[DUTY_W];
    end
    if (cmd.pass_scaled) begin
      scaled <= cur;
    end
    if (cmd.take_scaled) begin
      scaled <= neg ? VAL_W'(-quotient) : quotient;
    end
    if (cmd.duty_min) begin
      duty[motor] <= min_thrust;
    end
    if (cmd.take_duty) begin
      duty[motor] <= duty_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      motor <= '0;
    end else if (cmd.find_max) begin
      motor <= '0;
    end else if (cmd.next_motor) begin
      motor <= motor + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.publish) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      duty_0 <= duty[0];
      duty_1 <= duty[1];
      duty_2 <= duty[2];
      duty_3 <= duty[3];
      read_value <= read_work;
    end
  end

endmodule

// File: rtl/mdp_ctrl.sv
`timescale 1ns / 1ps

module mdp_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  mdp_pkg::status_t  status,
  output mdp_pkg::cmd_t     cmd
);
  import mdp_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (item_valid) begin
          state_next = ST_MAX;
        end
      end
      ST_MAX: state_next = ST_SCALE_MUL;
      ST_SCALE_MUL: state_next = status.rescale ? ST_SCALE_DIV : ST_MAP_MUL;
      ST_SCALE_DIV: state_next = ST_SCALE_WAIT;
      ST_SCALE_WAIT: begin
        if (status.div_done) begin
          state_next = ST_MAP_MUL;
        end
      end
      ST_MAP_MUL: state_next = status.map_trivial ? ST_NEXT : ST_MAP_DIV;
      ST_MAP_DIV: state_next = ST_MAP_WAIT;
      ST_MAP_WAIT: begin
        if (status.div_done) begin
          state_next = ST_NEXT;
        end
      end
      ST_NEXT: state_next = status.last ? ST_OUT : ST_SCALE_MUL;
      ST_OUT: begin
        if (status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    item_stall = 1'b1;
    case (state)
      ST_IDLE: begin
        item_stall = 1'b0;
        cmd.accept = item_valid;
      end
      ST_MAX: cmd.find_max = 1'b1;
      ST_SCALE_MUL: begin
        cmd.mul_scale = status.rescale;
        cmd.pass_scaled = !status.rescale;
      end
      ST_SCALE_DIV: cmd.div_start = 1'b1;
      ST_SCALE_WAIT: cmd.take_scaled = status.div_done;
      ST_MAP_MUL: begin
        cmd.mul_map = !status.map_trivial;
        cmd.duty_min = status.map_trivial;
      end
      ST_MAP_DIV: begin
        cmd.div_start = 1'b1;
        cmd.div_map = 1'b1;
      end
      ST_MAP_WAIT: cmd.take_duty = status.div_done;
      ST_NEXT: cmd.next_motor = !status.last;
      ST_OUT: cmd.publish = status.out_free;
      default: begin
      end
    endcase
  end

endmodule
